/* rtl/core/assert_macros.svh */
// Assertion macros shared by the substring finder RTL.
// Expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SFMF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfmf assertion failed");

// Next-cycle implication.
`define SFMF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfmf assertion failed");

`endif

/* rtl/core/sfmf_pkg.sv */
// Package for the substring first-match finder.
// Holds control struct, input kind codes and result status codes; no dependencies.
`timescale 1ns / 1ps

package sfmf_pkg;

    typedef enum logic
    {
        KIND_PATTERN = 1'b0,
        KIND_TEXT    = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_FOUND     = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    // Broadcast from the top level to every cell of the chain.
    typedef struct packed
    {
        logic       load;
        logic       shift;
        logic       clear;
        logic [7:0] data;
    } cell_ctrl_t;

endpackage

/* rtl/core/sfmf_cell.sv */
// One pattern position: stored pattern byte and its partial-match bit.
// Depends on sfmf_pkg.
`timescale 1ns / 1ps

module sfmf_cell
    import sfmf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       sel,
    input  logic       active,
    input  logic       match_in,
    output logic       hit,
    output logic       match
);

    logic [7:0] pat_reg;
    logic       match_reg;
    logic       match_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load && sel)
        begin
            pat_reg <= ctrl.data;
        end
    end

    assign hit = active & match_in & (pat_reg == ctrl.data);

    always_comb
    begin
        if (ctrl.clear)
        begin
            match_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            match_next = hit;
        end
        else
        begin
            match_next = match_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match = match_reg;

endmodule

/* rtl/core/sfmf_chain.sv */
// Row of sfmf_cell instances; match bits pass from each cell to the next.
// Depends on sfmf_pkg and sfmf_cell.
`timescale 1ns / 1ps

module sfmf_chain
    import sfmf_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int LEN_W = $clog2(DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [LEN_W-1:0] len,
    output logic             found
);

    `include "assert_macros.svh"

    logic [DEPTH-1:0] match_vec;
    logic [DEPTH-1:0] hit_vec;
    logic [DEPTH-1:0] last_vec;

    for (genvar j = 0; j < DEPTH; j++)
    begin : g_cell
        logic prev;
        logic sel;
        logic active;

        if (j == 0)
        begin : g_head
            assign prev = 1'b1;
        end
        else
        begin : g_body
            assign prev = match_vec[j-1];
        end

        assign sel         = (len == LEN_W'(j));
        assign active      = (len > LEN_W'(j));
        assign last_vec[j] = (len == LEN_W'(j + 1));

        sfmf_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .sel      (sel),
            .active   (active),
            .match_in (prev),
            .hit      (hit_vec[j]),
            .match    (match_vec[j])
        );
    end

    // Final pattern position matched on this byte.
    assign found = |(hit_vec & last_vec);

    `SFMF_ASSERT_IMP(a_one_last, 1'b1, $onehot0(last_vec))
    `SFMF_ASSERT_IMP(a_match_in_range, 1'b1, (match_vec & ~(last_vec | (last_vec - 1'b1))) == '0)

endmodule

/* rtl/core/substring_first_match_finder.sv */
// Top level of the substring first-match finder: stream ports, pattern length,
// text position, answer control and the result register. Uses sfmf_pkg, sfmf_chain.
`timescale 1ns / 1ps

// Loads a pattern (kind 0) of up to MAX_PATTERN_BYTES bytes, then scans a text
// (kind 1) and returns one result per text: the offset of the leftmost match,
// not found at the text's last transfer, or overflow when the pattern was too
// long. Input transfers can follow one another with no gaps between them:
// each text byte updates all pattern cells of the chain in the cycle it is
// taken. A result is visible in the output register the cycle after the
// deciding transfer; input stays open while the result waits unless the output
// register is full and the sink is stalled.
module substring_first_match_finder
    import sfmf_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 64,
    parameter int OFFSET_BITS       = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic [1:0]  s_axis_tuser,   // [0] kind, [1] has_byte
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] match_offset
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    `include "assert_macros.svh"

    localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PATTERN_BYTES);
    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic                   loading_reg, loading_next;
    logic                   ans_reg, ans_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg, out_status_next;
    logic [OFFSET_BITS-1:0] out_offset_reg, out_offset_next;

    logic                   xfer;
    logic                   is_text;
    logic                   has_byte;
    logic                   start;
    logic [LEN_W-1:0]       len_base;
    logic [LEN_W-1:0]       len_m1;
    logic [OFFSET_BITS-1:0] match_off;
    logic                   found;
    logic                   emit;
    cell_ctrl_t             ctrl;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign xfer     = s_axis_tvalid && s_axis_tready;
    assign is_text  = (kind_t'(s_axis_tuser[0]) == KIND_TEXT);
    assign has_byte = s_axis_tuser[1];
    assign start    = !is_text && !loading_reg;
    assign len_base = start ? '0 : len_reg;
    assign len_m1   = len_reg - 1'b1;
    assign match_off = pos_reg - OFFSET_BITS'(len_m1);

    always_comb
    begin
        ctrl.data  = s_axis_tdata;
        ctrl.load  = xfer && !is_text && has_byte && (len_base < LEN_MAX);
        ctrl.shift = xfer && is_text && !ans_reg && !ovf_reg && (len_reg != '0) && has_byte;
        ctrl.clear = xfer && (is_text ? s_axis_tlast : start);
    end

    sfmf_chain #(
        .DEPTH (MAX_PATTERN_BYTES),
        .LEN_W (LEN_W)
    ) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .len   (len_base),
        .found (found)
    );

    always_comb
    begin
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        loading_next    = loading_reg;
        ans_next        = ans_reg;
        pos_next        = pos_reg;
        emit            = 1'b0;
        out_status_next = out_status_reg;
        out_offset_next = out_offset_reg;

        if (xfer && !is_text)
        begin
            len_next     = len_base;
            ovf_next     = start ? 1'b0 : ovf_reg;
            loading_next = !s_axis_tlast;
            if (start)
            begin
                ans_next = 1'b0;
                pos_next = '0;
            end
            if (has_byte)
            begin
                if (len_base < LEN_MAX)
                begin
                    len_next = len_base + 1'b1;
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end
        else if (xfer)
        begin
            loading_next = 1'b0;
            if (!ans_reg)
            begin
                if (ovf_reg)
                begin
                    emit            = 1'b1;
                    out_status_next = STATUS_OVERFLOW;
                    out_offset_next = '0;
                end
                else if (len_reg == '0)
                begin
                    emit            = 1'b1;
                    out_status_next = STATUS_FOUND;
                    out_offset_next = '0;
                end
                else if (has_byte)
                begin
                    if (found)
                    begin
                        emit            = 1'b1;
                        out_status_next = STATUS_FOUND;
                        out_offset_next = match_off;
                    end
                    if (pos_reg != POS_MAX)
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                if (!emit && s_axis_tlast)
                begin
                    emit            = 1'b1;
                    out_status_next = STATUS_NOT_FOUND;
                    out_offset_next = '0;
                end
                ans_next = emit;
            end
            if (s_axis_tlast)
            begin
                ans_next = 1'b0;
                pos_next = '0;
            end
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            loading_reg   <= 1'b0;
            ans_reg       <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            loading_reg   <= loading_next;
            ans_reg       <= ans_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= out_status_next;
            out_offset_reg <= out_offset_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = 32'(out_offset_reg);

    `SFMF_ASSERT_IMP(a_len_bound, 1'b1, len_reg <= LEN_MAX)
    `SFMF_ASSERT_IMP(a_ovf_full, ovf_reg, len_reg == LEN_MAX)
    `SFMF_ASSERT_NXT(a_emit_shown, emit, m_axis_tvalid)
    `SFMF_ASSERT_IMP(a_no_overrun, emit, !out_valid_reg || m_axis_tready)

endmodule
